@@ rtl/gnms_pkg.sv @@
// Shared types and constants of the gradient non-max suppression block.
`default_nettype none

package gnms_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd2704;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1520;

    // Output codes
    localparam logic [7:0] CODE_EDGE = 8'd128;
    localparam logic [7:0] CODE_NONE = 8'd255;

    // tan(22.5) and tan(67.5) in Q2.32
    localparam logic [33:0] TAN_LOW  = 34'd1779033704;
    localparam logic [33:0] TAN_HIGH = 34'd10368968296;

    localparam int MAG_W  = 15;
    localparam int GRAD_W = 16;

    // Quantized gradient direction
    typedef enum logic [1:0] {
        DIR_H,
        DIR_V,
        DIR_D45,
        DIR_D135
    } t_dir;

    // One line-buffer word: two magnitude lines plus the gradients of one line
    typedef struct packed {
        logic [MAG_W-1:0]  mag_older;
        logic [MAG_W-1:0]  mag_newer;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
    } t_line_word;

endpackage

`default_nettype wire

@@ rtl/gnms_dir.sv @@
// Gradient direction quantizer: sector test of |gy| against tan(22.5)/tan(67.5) * |gx|.
`default_nettype none

module gnms_dir
    import gnms_pkg::*;
(
    input  wire logic [GRAD_W-1:0] i_grad_x,
    input  wire logic [GRAD_W-1:0] i_grad_y,
    output t_dir                   o_dir
);

    logic [GRAD_W-1:0] abs_x;
    logic [GRAD_W-1:0] abs_y;
    logic [49:0]       lhs;
    logic [49:0]       prod_low;
    logic [49:0]       prod_high;

    // two's complement magnitude; -32768 gives 32768 as unsigned
    assign abs_x = i_grad_x[GRAD_W-1] ? (~i_grad_x + 16'd1) : i_grad_x;
    assign abs_y = i_grad_y[GRAD_W-1] ? (~i_grad_y + 16'd1) : i_grad_y;

    assign lhs       = {2'b00, abs_y, 32'd0};
    assign prod_low  = 50'(abs_x) * 50'(TAN_LOW);
    assign prod_high = 50'(abs_x) * 50'(TAN_HIGH);

    always_comb begin
        if (((abs_x == '0) && (abs_y == '0)) || (lhs < prod_low)) begin
            o_dir = DIR_H;
        end else if (lhs >= prod_high) begin
            o_dir = DIR_V;
        end else if (i_grad_x[GRAD_W-1] == i_grad_y[GRAD_W-1]) begin
            o_dir = DIR_D45;
        end else begin
            o_dir = DIR_D135;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gradient_non_max_suppression.sv @@
// The first result of a request is valid once the request has passed the window stage
//   and then the result register; later results follow while earlier results still wait.
// Throughput: one pixel per cycle while results are taken; a row end or last-row pixel that
//   causes several results holds the input until its last result is taken (output sequencer).
// The line buffer is one 62-bit wide memory: read at accept, written back as the pixel leaves.
// Reset clears counters, window, direction; frame size to default; line memory not cleared.
`default_nettype none

module gradient_non_max_suppression
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input pixel stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [47:0]          i_s_tdata,   // grad_magnitude[14:0], grad_x[30:15],
                                                   // grad_y[46:31], zero [47]
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [31:0]               o_m_tdata,   // pixel_row[10:0], pixel_col[22:11],
                                                   // edge_code[30:23], zero [31]
    output logic                      o_m_tlast,   // last_of_run
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [12:0]          i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
    localparam logic [13:0] MAXH = 14'(MAX_HEIGHT);

    // ---------------- configuration ----------------
    logic [12:0]   r_frame_width;
    logic [11:0]   r_frame_height;
    logic [CW-1:0] w_m1;
    logic [RW-1:0] h_m1;
    logic [13:0]   fw_ext;
    logic [13:0]   fh_ext;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready &&
                    ((i_cfg_index == CFG_FRAME_WIDTH) || (i_cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[11:0];
            end
        end
    end

    // clamped size minus one
    assign fw_ext = {1'b0, r_frame_width};
    assign fh_ext = {2'b00, r_frame_height};

    always_comb begin
        if (fw_ext < 14'd3) begin
            w_m1 = CW'(2);
        end else if (fw_ext > MAXW) begin
            w_m1 = CW'(MAXW - 14'd1);
        end else begin
            w_m1 = CW'(fw_ext - 14'd1);
        end
        if (fh_ext < 14'd3) begin
            h_m1 = RW'(2);
        end else if (fh_ext > MAXH) begin
            h_m1 = RW'(MAXH - 14'd1);
        end else begin
            h_m1 = RW'(fh_ext - 14'd1);
        end
    end

    // ---------------- input / counters ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          in_acc;
    logic          end_row;
    logic          last_row;
    logic          b_adv;
    logic          c_free;

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign end_row  = (r_col >= w_m1);
    assign last_row = (r_row >= h_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- line memory ----------------
    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd;
    t_line_word wr_word;

    // ---------------- stage B: window and classification ----------------
    logic              r_b_valid;
    logic [MAG_W-1:0]  r_b_mag;
    logic [GRAD_W-1:0] r_b_gx;
    logic [GRAD_W-1:0] r_b_gy;
    logic [CW-1:0]     r_b_col;
    logic [RW-1:0]     r_b_row;
    logic              r_b_end;
    logic              r_b_last;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_mem[r_col];
        end
        if (b_adv) begin
            r_mem[r_b_col] <= wr_word;
        end
    end

    assign o_s_tready = !r_b_valid || c_free;
    assign b_adv      = r_b_valid && c_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_b_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_mag  <= i_s_tdata[14:0];
            r_b_gx   <= i_s_tdata[30:15];
            r_b_gy   <= i_s_tdata[46:31];
            r_b_col  <= r_col;
            r_b_row  <= r_row;
            r_b_end  <= end_row;
            r_b_last <= last_row;
        end
    end

    assign wr_word = '{mag_older: r_rd.mag_newer, mag_newer: r_b_mag,
                       gx: r_b_gx, gy: r_b_gy};

    // window [column][row]; row 0 oldest line, column 2 newest pixel
    logic [MAG_W-1:0] r_win [3][3];
    logic [MAG_W-1:0] n_win [3][3];
    t_dir             r_dir;
    t_dir             n_dir;
    logic [MAG_W-1:0] nb1;
    logic [MAG_W-1:0] nb2;
    logic [MAG_W-1:0] ctr;
    logic             is_edge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[0][i] = r_win[1][i];
            n_win[1][i] = r_win[2][i];
        end
        n_win[2][0] = r_rd.mag_older;
        n_win[2][1] = r_rd.mag_newer;
        n_win[2][2] = r_b_mag;
    end

    // direction of the next center, from the gradients read out of the line
    gnms_dir u_dir (
        .i_grad_x (r_rd.gx),
        .i_grad_y (r_rd.gy),
        .o_dir    (n_dir)
    );

    always_comb begin
        ctr = n_win[1][1];
        case (r_dir)
            DIR_H: begin
                nb1 = n_win[0][1];
                nb2 = n_win[2][1];
            end
            DIR_V: begin
                nb1 = n_win[1][0];
                nb2 = n_win[1][2];
            end
            DIR_D45: begin
                nb1 = n_win[0][0];
                nb2 = n_win[2][2];
            end
            DIR_D135: begin
                nb1 = n_win[2][0];
                nb2 = n_win[0][2];
            end
            default: begin
                nb1 = n_win[0][1];
                nb2 = n_win[2][1];
            end
        endcase
        is_edge = (r_b_row >= RW'(2)) && (r_b_col >= CW'(2)) &&
                  (ctr >= nb1) && (ctr >= nb2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            r_dir <= DIR_H;
        end else if (b_adv) begin
            r_win <= n_win;
            r_dir <= n_dir;
        end
    end

    // ---------------- stage C: result sequencer ----------------
    logic [3:0]    r_c_mask;
    logic [CW-1:0] r_c_col;
    logic [RW-1:0] r_c_row;
    logic [CW-1:0] r_c_wm1;
    logic          r_c_edge;
    logic [3:0]    n_mask;
    logic [3:0]    low_bit;
    logic          last_res;
    logic          b_col_nz;
    logic          b_row_nz;

    assign low_bit  = r_c_mask & (~r_c_mask + 4'd1);
    assign last_res = ((r_c_mask & ~low_bit) == 4'd0);
    assign c_free   = (r_c_mask == 4'd0) || (i_m_tready && last_res);

    assign b_col_nz = (r_b_col != '0);
    assign b_row_nz = (r_b_row != '0);
    assign n_mask   = {r_b_last && r_b_end, r_b_last && b_col_nz,
                       b_row_nz && r_b_end, b_row_nz && b_col_nz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_mask <= '0;
        end else if (c_free) begin
            r_c_mask <= b_adv ? n_mask : 4'd0;
        end else if (i_m_tready) begin
            r_c_mask <= r_c_mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_wm1  <= w_m1;
            r_c_edge <= is_edge;
        end
    end

    logic [RW-1:0] out_row;
    logic [CW-1:0] out_col;
    logic [7:0]    out_code;

    always_comb begin
        out_code = CODE_NONE;
        case (low_bit)
            4'b0001: begin
                out_row  = r_c_row - RW'(1);
                out_col  = r_c_col - CW'(1);
                out_code = r_c_edge ? CODE_EDGE : CODE_NONE;
            end
            4'b0010: begin
                out_row = r_c_row - RW'(1);
                out_col = r_c_wm1;
            end
            4'b0100: begin
                out_row = r_c_row;
                out_col = r_c_col - CW'(1);
            end
            default: begin
                out_row = r_c_row;
                out_col = r_c_wm1;
            end
        endcase
    end

    assign o_m_tvalid = (r_c_mask != 4'd0);
    assign o_m_tlast  = last_res;
    assign o_m_tdata  = {1'b0, out_code, 12'(out_col), 11'(out_row)};

endmodule

`default_nettype wire

@@ sim/nms_scoreboard_pkg.sv @@
// Scoreboard class with a predictor of the non-max suppression block.
package nms_scoreboard_pkg;
    import gnms_pkg::*;

    localparam int NMS_MAX_COLS = 4096;
    localparam int NMS_MAX_ROWS = 2048;

    typedef struct packed {
        logic [10:0] row;
        logic [11:0] col;
        logic [7:0]  code;
        logic        last;
    } t_classified;

    class nms_scoreboard;
        logic [12:0] width_reg;
        logic [11:0] height_reg;
        logic [14:0] mag_old_line [NMS_MAX_COLS];
        logic [14:0] mag_new_line [NMS_MAX_COLS];
        logic [15:0] gx_mem [NMS_MAX_COLS];
        logic [15:0] gy_mem [NMS_MAX_COLS];
        logic [14:0] win [3][3];
        logic [15:0] ctr_gx;
        logic [15:0] ctr_gy;
        int unsigned col_cnt;
        int unsigned row_cnt;
        t_classified classified_q[$];
        int errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            for (int i = 0; i < NMS_MAX_COLS; i++) begin
                mag_old_line[i] = '0;
                mag_new_line[i] = '0;
                gx_mem[i] = '0;
                gy_mem[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            ctr_gx  = '0;
            ctr_gy  = '0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
        endfunction

        function int pending();
            return classified_q.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [12:0] data);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = data;
            else if (idx == CFG_FRAME_HEIGHT)
                height_reg = data[11:0];
            else
                return;
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void push_pixel(int unsigned row, int unsigned col, logic [7:0] code,
                                 logic last);
            t_classified item;
            item.row  = row[10:0];
            item.col  = col[11:0];
            item.code = code;
            item.last = last;
            classified_q.push_back(item);
        endfunction

        // One accepted pixel: shift the window, classify the center, emit results
        function void note_pixel(logic [47:0] data);
            logic [14:0] m;
            logic [15:0] gx;
            logic [15:0] gy;
            int unsigned w, h, c, r;
            bit end_row, last_row, e1, e2, e3, e4;
            logic [7:0] code;
            logic [16:0] ax, ay;
            logic [63:0] lhs, t_lo, t_hi;
            logic [14:0] n1, n2;
            t_dir dir;
            m  = data[14:0];
            gx = data[30:15];
            gy = data[46:31];
            w = (width_reg < 3) ? 3 : ((width_reg > NMS_MAX_COLS) ? NMS_MAX_COLS : width_reg);
            h = (height_reg < 3) ? 3 : ((height_reg > NMS_MAX_ROWS) ? NMS_MAX_ROWS : height_reg);
            c = col_cnt;
            r = row_cnt;
            end_row  = (c >= w - 1);
            last_row = (r >= h - 1);

            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = mag_old_line[c];
            win[1][2] = mag_new_line[c];
            win[2][2] = m;

            code = CODE_NONE;
            if (r >= 2 && c >= 2) begin
                ax = ctr_gx[15] ? (17'h10000 - {1'b0, ctr_gx}) : {1'b0, ctr_gx};
                ay = ctr_gy[15] ? (17'h10000 - {1'b0, ctr_gy}) : {1'b0, ctr_gy};
                lhs  = {15'b0, ay, 32'b0};
                t_lo = 64'(TAN_LOW) * 64'(ax);
                t_hi = 64'(TAN_HIGH) * 64'(ax);
                if ((ax == 0 && ay == 0) || lhs < t_lo)
                    dir = DIR_H;
                else if (lhs >= t_hi)
                    dir = DIR_V;
                else if (ctr_gx[15] == ctr_gy[15])
                    dir = DIR_D45;
                else
                    dir = DIR_D135;
                case (dir)
                    DIR_H: begin
                        n1 = win[1][0];
                        n2 = win[1][2];
                    end
                    DIR_V: begin
                        n1 = win[0][1];
                        n2 = win[2][1];
                    end
                    DIR_D45: begin
                        n1 = win[0][0];
                        n2 = win[2][2];
                    end
                    default: begin
                        n1 = win[0][2];
                        n2 = win[2][0];
                    end
                endcase
                code = (win[1][1] >= n1 && win[1][1] >= n2) ? CODE_EDGE : CODE_NONE;
            end

            ctr_gx = gx_mem[c];
            ctr_gy = gy_mem[c];
            gx_mem[c] = gx;
            gy_mem[c] = gy;
            mag_old_line[c] = mag_new_line[c];
            mag_new_line[c] = m;

            e1 = (r >= 1 && c >= 1);
            e2 = (r >= 1 && end_row);
            e3 = (last_row && c >= 1);
            e4 = (last_row && end_row);
            if (e1) push_pixel(r - 1, c - 1, code, !(e2 || e3 || e4));
            if (e2) push_pixel(r - 1, w - 1, CODE_NONE, !(e3 || e4));
            if (e3) push_pixel(r, c - 1, CODE_NONE, !e4);
            if (e4) push_pixel(r, w - 1, CODE_NONE, 1'b1);

            if (end_row) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void compare(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                errors++;
                $error("%s expected %0d actual %0d", field, want, got);
            end
        endfunction

        function void check_result(logic [31:0] data, logic last);
            t_classified want;
            if (classified_q.size() == 0) begin
                errors++;
                $error("unexpected result row %0d col %0d", data[10:0], data[22:11]);
                return;
            end
            want = classified_q.pop_front();
            compare("pixel_row", 12'(want.row), 12'(data[10:0]));
            compare("pixel_col", want.col, data[22:11]);
            compare("edge_code", 12'(want.code), 12'(data[30:23]));
            compare("last_of_run", 12'(want.last), 12'(last));
        endfunction
    endclass

endpackage

@@ sim/tb.sv @@
// Testbench of the gradient non-max suppression block: directed and random frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gnms_pkg::*;
    import nms_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    // 5x5 directed frame; inner pixels cover every direction and the sector edges
    localparam int DIR_MAG [25] = '{32767, 0, 32767, 0, 32767,
                                    5, 9, 9, 3, 0,
                                    7, 9, 8, 9, 32767,
                                    1, 9, 2, 9, 6,
                                    0, 32767, 4, 9, 1};
    localparam int DIR_GX [25] = '{-32768, 32767, -1, 1, 0,
                                   32767, 0, 32767, 1000, -32768,
                                   0, 100, -100, -32768, -1,
                                   1000, 1000, -1000, 1000, -5,
                                   0, -32768, 32767, 1, -2};
    localparam int DIR_GY [25] = '{32767, -32768, -1, -1, 0,
                                   32767, 0, 0, 2415, 0,
                                   32767, 100, 100, -32768, 1,
                                   2415, 414, 415, 2414, -3,
                                   -1, -32768, 32767, 0, 7};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [47:0]          i_s_tdata = '0;
    logic                 i_m_tready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [12:0]          i_cfg_data = '0;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire [31:0]           o_m_tdata;
    wire                  o_m_tlast;
    wire                  o_cfg_ready;

    bit steady = 1'b0;
    int cycles = 0;
    nms_scoreboard sb = new();

    gradient_non_max_suppression u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready)
                sb.note_pixel(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] random_grad();
        logic [15:0] g;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: g = 16'($urandom);
            5, 6, 7:       g = 16'(int'($urandom_range(8)) - 4);
            8: begin
                case ($urandom_range(3))
                    0:       g = 16'h8000;
                    1:       g = 16'h7FFF;
                    2:       g = 16'hFFFF;
                    default: g = 16'h0001;
                endcase
            end
            default: g = 16'h0000;
        endcase
        return g;
    endfunction

    // small magnitudes often, so window ties and near-ties come up
    function automatic logic [47:0] random_pixel();
        logic [14:0] m;
        case ($urandom_range(4))
            0, 1:    m = 15'($urandom);
            2, 3:    m = 15'($urandom_range(7));
            default: m = $urandom_range(1) ? 15'h7FFF : 15'h0000;
        endcase
        return {1'b0, random_grad(), random_grad(), m};
    endfunction

    task automatic send_pixel(input logic [47:0] data);
        if (!steady) begin
            while ($urandom_range(99) < 38) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain: stop input, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned rand_items, n, cur_w, cur_h, wv, hv, sel;
        int phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame size: first row only, no results
        repeat (6) send_pixel(random_pixel());
        wait_idle();

        write_cfg(CFG_FRAME_WIDTH, 13'd5);
        write_cfg(CFG_FRAME_HEIGHT, 12'd5);
        for (int k = 0; k < 25; k++)
            send_pixel({1'b0, 16'(DIR_GY[k]), 16'(DIR_GX[k]), 15'(DIR_MAG[k])});
        wait_idle();

        cur_w = 5;
        cur_h = 5;
        rand_items = 0;
        phase = 0;
        while (rand_items < 200) begin
            sel = $urandom_range(9);
            if (sel == 0) begin
                // write to an unused index: frame position must carry on
                write_cfg($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B, 13'($urandom));
            end else begin
                if (sel != 1) begin
                    case ($urandom_range(9))
                        0:       wv = $urandom_range(2);
                        1:       wv = $urandom_range(20, 9);
                        default: wv = $urandom_range(8, 3);
                    endcase
                    write_cfg(CFG_FRAME_WIDTH, 13'(wv));
                    cur_w = (wv < 3) ? 3 : wv;
                end
                hv = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
                write_cfg(CFG_FRAME_HEIGHT, 12'(hv));
                cur_h = (hv < 3) ? 3 : hv;
            end
            if ($urandom_range(1))
                n = cur_w * cur_h * $urandom_range(2, 1);
            else
                n = $urandom_range(2 * cur_w * cur_h + 2, 2);
            if (n > 80)
                n = 80;
            if (n > 210 - rand_items)
                n = 210 - rand_items;
            steady = (phase == 1 || phase == 2);
            repeat (n) send_pixel(random_pixel());
            wait_idle();
            steady = 1'b0;
            rand_items += n;
            phase++;
        end

        // sizes below the minimum clamp to 3x3
        write_cfg(CFG_FRAME_WIDTH, 13'd0);
        write_cfg(CFG_FRAME_HEIGHT, 12'd0);
        repeat (11) send_pixel(random_pixel());
        wait_idle();

        // all-ones sizes clamp to the maximum
        write_cfg(CFG_FRAME_WIDTH, 13'h1FFF);
        write_cfg(CFG_FRAME_HEIGHT, 12'hFFF);
        repeat (20) send_pixel(random_pixel());
        wait_idle();

        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
